FILE: hw/rtl/numeric_literal_parser_macros.svh
// Assertion macros used by the parser RTL.
`ifndef NUMERIC_LITERAL_PARSER_MACROS_SVH
`define NUMERIC_LITERAL_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising clock edge outside reset.
`define NLP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define NLP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define NLP_ASSERT(name, clk, rst_n, prop, msg)
`define NLP_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

FILE: hw/rtl/nlp_pkg.sv
package nlp_pkg;

  // One character of a literal with its framing and suffix.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
    logic [2:0] suffix;
  } in_item_t;

  // One parse result.
  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         kind;
    logic [2:0]         error;
  } out_item_t;

  // Suffix codes.
  localparam logic [2:0] SufNone  = 3'd0;
  localparam logic [2:0] SufB     = 3'd1;
  localparam logic [2:0] SufL     = 3'd2;
  localparam logic [2:0] SufF     = 3'd3;
  localparam logic [2:0] SufOther = 3'd4;

  // Result kinds.
  localparam logic [1:0] KindInt    = 2'd0;
  localparam logic [1:0] KindLong   = 2'd1;
  localparam logic [1:0] KindFloat  = 2'd2;
  localparam logic [1:0] KindDouble = 2'd3;

  // Error codes.
  localparam logic [2:0] ErrNone        = 3'd0;
  localparam logic [2:0] ErrHexEmpty    = 3'd1;
  localparam logic [2:0] ErrHexOverflow = 3'd2;
  localparam logic [2:0] ErrBinOverflow = 3'd3;
  localparam logic [2:0] ErrOctOverflow = 3'd4;
  localparam logic [2:0] ErrDecOverflow = 3'd5;
  localparam logic [2:0] ErrBadDigit    = 3'd6;
  localparam logic [2:0] ErrBadSuffix   = 3'd7;

endpackage

FILE: hw/rtl/nlp_in_stage.sv
module nlp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  nlp_pkg::in_item_t in_data_i,
  output logic              in_stall_o,
  input  logic              take_i,
  output logic              item_valid_o,
  output nlp_pkg::in_item_t item_o
);
  import nlp_pkg::*;

  logic     valid_q, valid_d;
  in_item_t data_q;
  logic     load;

  // The register may refill in the same cycle that its item moves on.
  assign in_stall_o = valid_q & ~take_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload holds while an item waits.
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

FILE: hw/rtl/nlp_core.sv
module nlp_core #(
  parameter int MaxLen = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  nlp_pkg::in_item_t  item_i,
  output nlp_pkg::out_item_t result_o
);
  import nlp_pkg::*;

  typedef enum logic [2:0] {
    ModePending = 3'd0,
    ModeDec     = 3'd1,
    ModeHex     = 3'd2,
    ModeOct     = 3'd3,
    ModeBin     = 3'd4
  } mode_e;

  typedef struct packed {
    logic [63:0] acc;
    logic [7:0]  sig_cnt;
    logic [7:0]  first_sig;
    logic        in_lz;
    logic        fault;
  } digit_state_t;

  localparam digit_state_t DigitReset = '{acc: 64'd0, sig_cnt: 8'd0, first_sig: 8'd0,
                                          in_lz: 1'b1, fault: 1'b0};
  localparam logic [7:0] MaxIdx    = 8'(MaxLen);
  localparam logic [7:0] CaseBit   = 8'h20;
  localparam logic [7:0] BadDigit  = 8'hFF;
  localparam logic [7:0] HexMaxSig = 8'd16;
  localparam logic [7:0] BinMaxSig = 8'd64;
  localparam logic [7:0] OctMaxSig = 8'd22;
  localparam logic [7:0] OctMaxSigNotOne = 8'd21;

  // Digit value of a character, letters of either case give 10 to 35.
  function automatic logic [7:0] digit_of(logic [7:0] c);
    logic [7:0] lc;
    lc = c | CaseBit;
    if (c >= "0" && c <= "9") begin
      return c - 8'("0");
    end else if (lc >= "a" && lc <= "z") begin
      return lc - 8'("a") + 8'd10;
    end
    return BadDigit;
  endfunction

  // Fold one character into the digit state; radix multiply is shift-add.
  function automatic digit_state_t feed(digit_state_t s, logic [7:0] c, mode_e m);
    digit_state_t r;
    logic [7:0]   d;
    logic [7:0]   base;
    logic [63:0]  prod;
    r = s;
    if (!(s.in_lz && c == "0")) begin
      if (s.in_lz) begin
        r.first_sig = c;
        r.in_lz     = 1'b0;
      end
      if (s.sig_cnt != 8'hFF) begin
        r.sig_cnt = s.sig_cnt + 8'd1;
      end
    end
    d = digit_of(c);
    case (m)
      ModeHex: begin
        base = 8'd16;
        prod = s.acc << 4;
      end
      ModeOct: begin
        base = 8'd8;
        prod = s.acc << 3;
      end
      ModeBin: begin
        base = 8'd2;
        prod = s.acc << 1;
      end
      default: begin
        base = 8'd10;
        prod = (s.acc << 3) + (s.acc << 1);
      end
    endcase
    if (d >= base) begin
      r.fault = 1'b1;
    end else begin
      r.acc = prod + {56'd0, d};
    end
    return r;
  endfunction

  logic [7:0]   idx_q, idx_d;
  mode_e        mode_q, mode_d;
  logic [7:0]   first_q, first_d;
  digit_state_t ds_q, ds_d;
  logic         frac_q, frac_d;

  logic [7:0]   c;
  logic [2:0]   suf;
  mode_e        mode_n;
  logic [7:0]   first_n;
  digit_state_t ds_n;
  logic         frac_n;
  logic         fits;
  out_item_t    res;

  assign c = item_i.ch;

  // Base selection and digit accumulation for the current character.
  always_comb begin
    suf     = (item_i.suffix > SufOther) ? SufOther : item_i.suffix;
    frac_n  = frac_q | (c == ".") | (c == "e");
    mode_n  = mode_q;
    ds_n    = ds_q;
    first_n = first_q;
    if (idx_q == 8'd0) begin
      first_n = c;
      if (item_i.is_last) begin
        mode_n = (suf == SufB) ? ModeBin : ModeDec;
        ds_n   = feed(ds_q, c, mode_n);
      end
    end else if (idx_q == 8'd1) begin
      if (c == "x") begin
        mode_n = ModeHex;
      end else if (suf == SufB) begin
        mode_n = ModeBin;
      end else if (suf == SufNone && first_q == "0" && c >= "0" && c <= "9") begin
        mode_n = ModeOct;
      end else begin
        mode_n = ModeDec;
      end
      if (mode_n != ModeHex) begin
        ds_n = feed(feed(ds_q, first_q, mode_n), c, mode_n);
      end
    end else begin
      ds_n = feed(ds_q, c, mode_q);
    end
  end

  assign fits = (&ds_n.acc[63:31]) | ~(|ds_n.acc[63:31]);

  // Result classification, checks in priority order.
  always_comb begin
    res.value = '0;
    res.kind  = KindInt;
    res.error = ErrNone;
    if (mode_n == ModeHex) begin
      if (idx_q == 8'd1) begin
        res.error = ErrHexEmpty;
      end else if (ds_n.sig_cnt > HexMaxSig) begin
        res.error = ErrHexOverflow;
      end else if (ds_n.fault) begin
        res.error = ErrBadDigit;
      end else begin
        res.value = ds_n.acc;
        res.kind  = fits ? KindInt : KindLong;
      end
    end else if (frac_n) begin
      if (suf == SufF) begin
        res.kind = KindFloat;
      end else if (suf == SufNone) begin
        res.kind = KindDouble;
      end else begin
        res.error = ErrBadSuffix;
      end
    end else if (suf == SufB) begin
      if (ds_n.sig_cnt > BinMaxSig) begin
        res.error = ErrBinOverflow;
      end else if (ds_n.fault) begin
        res.error = ErrBadDigit;
      end else begin
        res.value = ds_n.acc;
        res.kind  = fits ? KindInt : KindLong;
      end
    end else if (suf == SufL) begin
      if (ds_n.fault) begin
        res.error = ErrBadDigit;
      end else begin
        res.value = ds_n.acc;
        res.kind  = KindLong;
      end
    end else if (suf != SufNone) begin
      res.error = ErrBadSuffix;
    end else if (mode_n == ModeOct) begin
      if (ds_n.sig_cnt > OctMaxSig ||
          (ds_n.sig_cnt > OctMaxSigNotOne && ds_n.first_sig != "1")) begin
        res.error = ErrOctOverflow;
      end else if (ds_n.fault) begin
        res.error = ErrBadDigit;
      end else begin
        res.value = ds_n.acc;
        res.kind  = fits ? KindInt : KindLong;
      end
    end else begin
      if (ds_n.fault) begin
        res.error = ErrBadDigit;
      end else if (fits) begin
        res.value = ds_n.acc;
      end else begin
        res.error = ErrDecOverflow;
      end
    end
  end

  assign result_o = res;

  // The last character returns every piece of state to its reset value.
  always_comb begin
    if (item_i.is_last) begin
      idx_d   = 8'd0;
      mode_d  = ModePending;
      first_d = 8'd0;
      ds_d    = DigitReset;
      frac_d  = 1'b0;
    end else begin
      idx_d   = (idx_q < MaxIdx) ? idx_q + 8'd1 : idx_q;
      mode_d  = mode_n;
      first_d = first_n;
      ds_d    = ds_n;
      frac_d  = frac_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 8'd0;
      mode_q  <= ModePending;
      first_q <= 8'd0;
      ds_q    <= DigitReset;
      frac_q  <= 1'b0;
    end else if (step_i) begin
      idx_q   <= idx_d;
      mode_q  <= mode_d;
      first_q <= first_d;
      ds_q    <= ds_d;
      frac_q  <= frac_d;
    end
  end

endmodule

FILE: hw/rtl/numeric_literal_parser.sv
// Channel  Direction  Signals                                Payload
// input    in         in_valid_i, in_stall_o, in_data_i      ch, is_last, suffix
// output   out        out_valid_o, out_stall_i, out_data_o   value, kind, error
//
// One character is taken in every cycle while in_stall_o is low; a literal's
// result passes through the input register, then the result register, before
// it is shown on out_valid_o and out_data_o.
// The digit logic between the two registers is combinational.
// Reset clears the handshake and parse state; no clearing pass is needed.
// in_stall_o rises only while a last character waits for a result register
// that still holds a result stalled by out_stall_i.
`include "numeric_literal_parser_macros.svh"

module numeric_literal_parser #(
  parameter int MAX_LITERAL_LEN = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  nlp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nlp_pkg::out_item_t out_data_o
);
  import nlp_pkg::*;

  logic      item_valid;
  in_item_t  item;
  logic      take;
  logic      emit;
  out_item_t result;

  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;

  // A character moves on unless it is a last one facing a full, stalled output.
  assign take = item_valid & (~item.is_last | ~out_valid_q | ~out_stall_i);
  assign emit = take & item.is_last;

  nlp_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .take_i      (take),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  nlp_core #(
    .MaxLen(MAX_LITERAL_LEN)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (take),
    .item_i  (item),
    .result_o(result)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks.
  `NLP_ASSERT(a_stall_needs_item, clk_i, rst_ni, in_stall_o |-> item_valid, "stall without item")
  `NLP_ASSERT(a_emit_into_free, clk_i, rst_ni, emit |-> (!out_valid_q || !out_stall_i), "result overwritten")
  `NLP_ASSERT(a_error_zeroes, clk_i, rst_ni, (out_valid_o && out_data_o.error != ErrNone) |-> (out_data_o.value == 64'sd0 && out_data_o.kind == KindInt), "error result not cleared")
  `NLP_ASSERT(a_float_zero, clk_i, rst_ni, (out_valid_o && (out_data_o.kind == KindFloat || out_data_o.kind == KindDouble)) |-> out_data_o.value == 64'sd0, "floating result has value")
  `NLP_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> (!out_valid_o && !in_stall_o), "busy in reset")

endmodule

FILE: sim/tb_numeric_literal_parser.sv
`timescale 1ns / 100ps

// Tracks the parse of each literal as characters are transferred in and holds
// the results the parser owes, oldest first.
class literal_scoreboard;
  localparam int MaxLiteralLen = 255;
  localparam int HexSigLimit = 16;
  localparam int BinSigLimit = 64;
  localparam int OctSigLimit = 22;
  localparam int OctSigLimitNotOne = 21;
  localparam int SigCountMax = 255;
  localparam int NotADigit = 255;
  localparam bit [7:0] CaseBit = 8'h20;
  localparam int PrintCap = 40;

  typedef enum bit [2:0] {
    RadixPending,
    RadixDec,
    RadixHex,
    RadixOct,
    RadixBin
  } radix_e;

  // Parse state of the literal in flight.
  bit [7:0]  char_idx;
  radix_e    radix;
  bit [7:0]  lead_char;
  bit [63:0] acc;
  bit [7:0]  sig_cnt;
  bit [7:0]  first_sig;
  bit        in_zeros;
  bit        saw_fraction;
  bit        bad_digit;

  nlp_pkg::out_item_t parsed_q[$];
  int fails;
  int chars_seen;
  int results_seen;
  bit [7:0] errors_hit;
  bit [3:0] kinds_hit;

  function new();
    clear_literal();
    fails = 0;
    chars_seen = 0;
    results_seen = 0;
    errors_hit = '0;
    kinds_hit = '0;
  endfunction

  function void clear_literal();
    char_idx = '0;
    radix = RadixPending;
    lead_char = '0;
    acc = '0;
    sig_cnt = '0;
    first_sig = '0;
    in_zeros = 1'b1;
    saw_fraction = 1'b0;
    bad_digit = 1'b0;
  endfunction

  // Digits 0-9, then letters of either case as 10 to 35.
  function int unsigned digit_value(bit [7:0] c);
    bit [7:0] lc;
    if (c >= "0" && c <= "9") return c - "0";
    lc = c | CaseBit;
    if (lc >= "a" && lc <= "z") return lc - "a" + 10;
    return NotADigit;
  endfunction

  function int unsigned radix_base();
    case (radix)
      RadixHex: return 16;
      RadixOct: return 8;
      RadixBin: return 2;
      default:  return 10;
    endcase
  endfunction

  // Count significant characters and fold one digit into the accumulator.
  function void absorb(bit [7:0] c);
    int unsigned base;
    int unsigned d;
    base = radix_base();
    if (!(in_zeros && c == "0")) begin
      if (in_zeros) begin
        first_sig = c;
        in_zeros = 1'b0;
      end
      if (sig_cnt < SigCountMax) sig_cnt++;
    end
    d = digit_value(c);
    if (d >= base) begin
      bad_digit = 1'b1;
    end else begin
      acc = acc * base + d;
    end
  endfunction

  function radix_e pick_radix(bit [7:0] second, bit has_second, bit [2:0] suf);
    if (has_second && second == "x") return RadixHex;
    if (suf == nlp_pkg::SufB) return RadixBin;
    if (suf == nlp_pkg::SufNone && has_second && lead_char == "0" &&
        second >= "0" && second <= "9") return RadixOct;
    return RadixDec;
  endfunction

  // Classify the finished literal; errors are checked in a fixed order.
  function nlp_pkg::out_item_t finish_literal(bit [2:0] suf);
    nlp_pkg::out_item_t r;
    bit [63:0] biased;
    bit fits;
    biased = acc + 64'h0000_0000_8000_0000;
    fits = (biased[63:32] == '0);
    r = '0;
    if (radix == RadixHex) begin
      if (char_idx == 1) r.error = nlp_pkg::ErrHexEmpty;
      else if (sig_cnt > HexSigLimit) r.error = nlp_pkg::ErrHexOverflow;
      else if (bad_digit) r.error = nlp_pkg::ErrBadDigit;
      else begin
        r.value = acc;
        r.kind = fits ? nlp_pkg::KindInt : nlp_pkg::KindLong;
      end
    end else if (saw_fraction) begin
      if (suf == nlp_pkg::SufF) r.kind = nlp_pkg::KindFloat;
      else if (suf == nlp_pkg::SufNone) r.kind = nlp_pkg::KindDouble;
      else r.error = nlp_pkg::ErrBadSuffix;
    end else if (suf == nlp_pkg::SufB) begin
      if (sig_cnt > BinSigLimit) r.error = nlp_pkg::ErrBinOverflow;
      else if (bad_digit) r.error = nlp_pkg::ErrBadDigit;
      else begin
        r.value = acc;
        r.kind = fits ? nlp_pkg::KindInt : nlp_pkg::KindLong;
      end
    end else if (suf == nlp_pkg::SufL) begin
      if (bad_digit) r.error = nlp_pkg::ErrBadDigit;
      else begin
        r.value = acc;
        r.kind = nlp_pkg::KindLong;
      end
    end else if (suf != nlp_pkg::SufNone) begin
      r.error = nlp_pkg::ErrBadSuffix;
    end else if (radix == RadixOct) begin
      if (sig_cnt > OctSigLimit || (sig_cnt > OctSigLimitNotOne && first_sig != "1"))
        r.error = nlp_pkg::ErrOctOverflow;
      else if (bad_digit) r.error = nlp_pkg::ErrBadDigit;
      else begin
        r.value = acc;
        r.kind = fits ? nlp_pkg::KindInt : nlp_pkg::KindLong;
      end
    end else begin
      if (bad_digit) r.error = nlp_pkg::ErrBadDigit;
      else if (fits) r.value = acc;
      else r.error = nlp_pkg::ErrDecOverflow;
    end
    return r;
  endfunction

  // Called for every character transferred into the parser.
  function void note_input(nlp_pkg::in_item_t it);
    bit [7:0] c;
    bit [2:0] suf;
    c = it.ch;
    suf = (it.suffix > nlp_pkg::SufOther) ? nlp_pkg::SufOther : it.suffix;
    chars_seen++;
    if (c == "." || c == "e") saw_fraction = 1'b1;

    // The base is settled by the second character, so the first one waits.
    if (char_idx == 0) begin
      lead_char = c;
      if (it.is_last) begin
        radix = pick_radix(8'h00, 1'b0, suf);
        absorb(lead_char);
      end
    end else if (char_idx == 1) begin
      radix = pick_radix(c, 1'b1, suf);
      if (radix != RadixHex) begin
        absorb(lead_char);
        absorb(c);
      end
    end else begin
      absorb(c);
    end

    if (!it.is_last) begin
      if (char_idx < MaxLiteralLen) char_idx++;
    end else begin
      parsed_q.insert(parsed_q.size(), finish_literal(suf));
      clear_literal();
    end
  endfunction

  task report(string msg);
    if (fails < PrintCap) $display("MISMATCH at %0t: %s", $realtime, msg);
    fails++;
  endtask

  // Called for every result transferred out of the parser.
  task check_result(nlp_pkg::out_item_t got);
    nlp_pkg::out_item_t want;
    if (parsed_q.size() == 0) begin
      report($sformatf("result with none pending: value=%0d kind=%0d error=%0d",
                       got.value, got.kind, got.error));
      return;
    end
    want = parsed_q.pop_front();
    results_seen++;
    errors_hit[want.error] = 1'b1;
    if (want.error == nlp_pkg::ErrNone) kinds_hit[want.kind] = 1'b1;
    if (got.value !== want.value)
      report($sformatf("result %0d value %0d, wanted %0d", results_seen, got.value,
                       want.value));
    if (got.kind !== want.kind)
      report($sformatf("result %0d kind %0d, wanted %0d", results_seen, got.kind,
                       want.kind));
    if (got.error !== want.error)
      report($sformatf("result %0d error %0d, wanted %0d", results_seen, got.error,
                       want.error));
  endtask
endclass

module tb_numeric_literal_parser;
  import nlp_pkg::*;

  localparam int TargetItems = 1450;
  localparam int LongHold = 70;
  localparam int TailCycles = 10;
  localparam int TimeoutNs = 2_000_000;
  localparam bit [2:0] SufReservedMax = 3'b111;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_data = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  literal_scoreboard sb = new();

  bit [7:0] lit_buf[$];
  int       chars_sent = 0;
  int       send_calm = 0;
  int       recv_calm = 0;
  int       in_stall_cycles = 0;
  bit       long_hold_req = 1'b0;

  numeric_literal_parser dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Idle cycles before the next transfer, with occasional stretches of none.
  function automatic int draw_idle(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(15, 40);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  function automatic bit [7:0] pick_from(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic bit [2:0] random_suffix(int none_pct);
    if ($urandom_range(0, 99) < none_pct) return SufNone;
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic void add_char(bit [7:0] c);
    lit_buf.insert(lit_buf.size(), c);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function automatic void add_digits(string set, int n);
    repeat (n) add_char(pick_from(set));
  endfunction

  // Offer one character and hold it until the transfer happens.
  task automatic send_item(bit [7:0] c, bit last, bit [2:0] suf);
    int gap;
    in_item_t it;
    gap = draw_idle(send_calm);
    it.ch = c;
    it.is_last = last;
    it.suffix = suf;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_buffer(bit [2:0] suf);
    foreach (lit_buf[i]) send_item(lit_buf[i], i == lit_buf.size() - 1, suf);
    lit_buf.delete();
  endtask

  task automatic send_text(string s, bit [2:0] suf);
    lit_buf.delete();
    add_text(s);
    send_buffer(suf);
  endtask

  // Stop offering characters until every pending result has come out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.parsed_q.size() != 0) @(posedge clk);
  endtask

  // Let the receiver hold off for a long stretch while short literals keep
  // coming, so the result register fills and the input side stalls.
  task automatic flood_while_held();
    long_hold_req = 1'b1;
    repeat (16) send_item(pick_from("0123456789"), 1'b1, SufNone);
  endtask

  // One random literal; most are well formed, the rest noise or broken.
  task automatic send_random_literal();
    int pick;
    int n;
    bit [2:0] suf;
    lit_buf.delete();
    pick = $urandom_range(0, 99);
    suf = SufNone;
    if (pick < 14) begin
      // Plain decimal, now and then long enough to leave the int range.
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 6);
      add_digits("0123456789", n);
      if ($urandom_range(0, 19) == 0) lit_buf[$urandom_range(0, n - 1)] = pick_from("gZ/:_");
      suf = random_suffix(70);
    end else if (pick < 20) begin
      // Values sitting on the int, long and significant-count limits.
      suf = random_suffix(75);
      case ($urandom_range(0, 11))
        0:  add_text("2147483647");
        1:  add_text("2147483648");
        2:  add_text("4294967295");
        3:  add_text("0x7fffffff");
        4:  add_text("0x80000000");
        5:  add_text("0xFFFFFFFF");
        6:  add_text("0xffffffffffffffff");
        7:  add_text("0x10000000000000000");
        8:  add_text("01777777777777777777777");
        9:  add_text("02000000000000000000000");
        10: add_text("0777777777777777777777");
        default: begin
          add_digits("1", $urandom_range(63, 65));
          suf = SufB;
        end
      endcase
    end else if (pick < 36) begin
      // Hex, sometimes with a nonzero first character or an upper-case X.
      add_char(($urandom_range(0, 9) == 0) ? pick_from("123456789") : "0");
      add_char(($urandom_range(0, 19) == 0) ? "X" : "x");
      if ($urandom_range(0, 3) == 0) add_digits("0", $urandom_range(1, 4));
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 8);
      add_digits("0123456789abcdefABCDEF", n);
      if (n > 0 && $urandom_range(0, 14) == 0) lit_buf[lit_buf.size() - 1] = pick_from("gG.x_");
      suf = random_suffix(50);
    end else if (pick < 50) begin
      // Octal around the significant-digit limits.
      add_char("0");
      if ($urandom_range(0, 3) == 0) add_digits("0", $urandom_range(1, 3));
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 23) : $urandom_range(1, 8);
      add_char($urandom_range(0, 1) ? "1" : pick_from("1234567"));
      add_digits("01234567", n - 1);
      if ($urandom_range(0, 14) == 0) lit_buf[lit_buf.size() - 1] = pick_from("89");
      suf = random_suffix(90);
    end else if (pick < 62) begin
      // Binary, sometimes right at the 64-digit limit.
      if ($urandom_range(0, 3) == 0) add_digits("0", $urandom_range(1, 4));
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 67) : $urandom_range(1, 12);
      add_char("1");
      add_digits("01", n - 1);
      if ($urandom_range(0, 14) == 0) lit_buf[$urandom_range(0, lit_buf.size() - 1)] = "2";
      suf = ($urandom_range(0, 9) == 0) ? random_suffix(0) : SufB;
    end else if (pick < 74) begin
      // Floating forms with a point, an exponent or both.
      add_digits("0123456789", $urandom_range(0, 3));
      if ($urandom_range(0, 2) != 0) begin
        add_char(".");
        add_digits("0123456789", $urandom_range(0, 3));
      end
      if ($urandom_range(0, 1) != 0) begin
        add_char("e");
        add_digits("0123456789", $urandom_range(0, 2));
      end
      if (lit_buf.size() == 0) add_char(".");
      suf = ($urandom_range(0, 3) == 0) ? random_suffix(0) :
            ($urandom_range(0, 1) ? SufF : SufNone);
    end else if (pick < 82) begin
      // Long suffix on decimal digits of any length.
      add_digits("0123456789",
                 ($urandom_range(0, 3) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6));
      suf = SufL;
    end else if (pick < 94) begin
      // Raw bytes with a suffix that changes from character to character.
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++)
        send_item(8'($urandom_range(0, 255)), i == n - 1, 3'($urandom_range(0, 7)));
      return;
    end else begin
      // A leading zero with an arbitrary second character.
      add_char("0");
      add_char(8'($urandom_range(0, 255)));
      add_digits("0123456789", $urandom_range(0, 3));
      suf = random_suffix(60);
    end
    send_buffer(suf);
  endtask

  // Every transfer on either side goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (in_valid && in_stall) in_stall_cycles++;
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Receiver: stalls a random while before each result, or long on request.
  initial begin
    int hold;
    wait (rst_n);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LongHold;
      end else begin
        hold = draw_idle(recv_calm);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Stimulus and end of run.
  initial begin
    bit pressure_a;
    bit pressure_b;
    bit long_done;
    pressure_a = 1'b0;
    pressure_b = 1'b0;
    long_done = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed literals: byte extremes, every kind, and the empty-hex, bad-digit and bad-suffix errors.
    send_item(8'h00, 1'b1, SufNone);
    send_item(8'hFF, 1'b1, SufReservedMax);
    send_text("0x", SufNone);
    send_text("9xF", SufL);
    send_text("08", SufNone);
    send_text("017", SufNone);
    send_text("1.5", SufF);
    send_text("2e", SufNone);
    send_text("7", SufL);
    send_text("101", SufB);
    send_text("9g", SufOther);
    send_text("z", SufNone);
    send_text("0", SufNone);
    wait_for_results();

    while (chars_sent < TargetItems) begin
      if (!pressure_a && chars_sent > 450) begin
        pressure_a = 1'b1;
        flood_while_held();
      end
      if (!long_done && chars_sent > 700) begin
        // Literals past the length limit: index and count saturate.
        long_done = 1'b1;
        wait_for_results();
        lit_buf.delete();
        add_text("0x");
        add_digits("0", 262);
        add_text("1f");
        send_buffer(SufNone);
        add_digits("0123456789", 280);
        send_buffer(SufNone);
      end
      if (!pressure_b && chars_sent > 1250) begin
        pressure_b = 1'b1;
        flood_while_held();
      end
      send_random_literal();
    end

    wait_for_results();
    repeat (TailCycles) @(posedge clk);

    $display("Run covered %0d characters and %0d checked results; input held off %0d cycles.",
             sb.chars_seen, sb.results_seen, in_stall_cycles);
    $display("Error codes reached (one bit per code): %b; kinds reached: %b.",
             sb.errors_hit, sb.kinds_hit);
    if (sb.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches in total.", sb.fails);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog in case the parser hangs.
  initial begin
    #(TimeoutNs);
    $display("Timed out with %0d results pending.", sb.parsed_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
